@@ hw/rtl/dmwbc_pkg.sv @@
// Shared types, widths, codes and parameter defaults for the direct-mapped
// write-back cache unit. No dependencies.
`timescale 1ns / 1ps

package dmwbc_pkg;

  // Fixed field widths of the request, result and configuration channels
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COST_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Geometry defaults
  localparam int unsigned CACHE_BYTES_DEF  = 4096;
  localparam int unsigned LINE_BYTES_DEF   = 16;
  localparam int unsigned WORD_BYTES_DEF   = 4;
  localparam int unsigned MEMORY_BYTES_DEF = 65536;

  // Cost register reset values
  localparam logic [COST_W-1:0] MEM_READ_COST_RST    = 16'd100;
  localparam logic [COST_W-1:0] MEM_WRITE_COST_RST   = 16'd50;
  localparam logic [COST_W-1:0] CACHE_READ_COST_RST  = 16'd1;
  localparam logic [COST_W-1:0] CACHE_WRITE_COST_RST = 16'd1;

  // Request operations
  typedef enum logic [FUNC_W-1:0] {
    FN_READ       = 2'd0,
    FN_WRITE      = 2'd1,
    FN_CLEAR_TIME = 2'd2,
    FN_INVALIDATE = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEM_READ_COST    = 2'd0,
    REG_MEM_WRITE_COST   = 2'd1,
    REG_CACHE_READ_COST  = 2'd2,
    REG_CACHE_WRITE_COST = 2'd3
  } cfg_reg_t;

endpackage

@@ hw/rtl/dmwbc_req_if.sv @@
// Request channel: operation, byte address and write word with valid/ready.
// Depends on dmwbc_pkg.
`timescale 1ns / 1ps

interface dmwbc_req_if;
  import dmwbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, func, address, write_data, input ready);
  modport sink   (input valid, func, address, write_data, output ready);
endinterface

@@ hw/rtl/dmwbc_rsp_if.sv @@
// Result channel: read word, hit and error flags, elapsed time with valid/ready.
// Depends on dmwbc_pkg.
`timescale 1ns / 1ps

interface dmwbc_rsp_if;
  import dmwbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              hit;
  logic              error;
  logic [TIME_W-1:0] elapsed_time;

  modport source (output valid, read_data, hit, error, elapsed_time, input ready);
  modport sink   (input valid, read_data, hit, error, elapsed_time, output ready);
endinterface

@@ hw/rtl/dmwbc_cfg_if.sv @@
// Configuration write channel: register index and data with valid/ready.
// Depends on dmwbc_pkg.
`timescale 1ns / 1ps

interface dmwbc_cfg_if;
  import dmwbc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COST_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dmwbc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps

module dmwbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/direct_mapped_writeback_cache_unit.sv @@
// A hit, an error, a time clear or an invalidate finishes in the line lookup state;
// a miss goes on from line lookup, with victim write-back and block fetch on the
// memory ports, to line fill. A finish waits while the result register is full and
// not taken. A new request is taken only once the unit is idle again.
// Reset: all lines invalid, time zero, cost registers to defaults; then a clearing
// pass zeroes the backing memory, MEM_SPAN/LINE_BYTES blocks (4096 by default).
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_unit #(
  parameter int unsigned CACHE_BYTES  = dmwbc_pkg::CACHE_BYTES_DEF,
  parameter int unsigned LINE_BYTES   = dmwbc_pkg::LINE_BYTES_DEF,
  parameter int unsigned WORD_BYTES   = dmwbc_pkg::WORD_BYTES_DEF,
  parameter int unsigned MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  dmwbc_req_if.sink   in_req,
  dmwbc_rsp_if.source out_rsp,
  dmwbc_cfg_if.sink   cfg_wr
);
  import dmwbc_pkg::*;

  // Geometry
  localparam int unsigned OFF_W      = $clog2(LINE_BYTES);
  localparam int unsigned NUM_LINES  = CACHE_BYTES / LINE_BYTES;
  localparam int unsigned IDX_W      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int unsigned CACHE_SH   = $clog2(CACHE_BYTES);
  localparam int unsigned TAG_W      = (ADDR_W > CACHE_SH) ? ADDR_W - CACHE_SH : 1;
  localparam int unsigned LINE_W     = 8 * LINE_BYTES;
  localparam int unsigned ENT_W      = 1 + TAG_W + LINE_W;
  localparam int unsigned ADDR_SPAN  = 1 << ADDR_W;
  localparam int unsigned MEM_SPAN   = (MEMORY_BYTES < ADDR_SPAN) ? MEMORY_BYTES : ADDR_SPAN;
  localparam int unsigned MEM_BLOCKS = MEM_SPAN / LINE_BYTES;
  localparam int unsigned MEM_AW     = (MEM_BLOCKS > 1) ? $clog2(MEM_BLOCKS) : 1;
  localparam int unsigned ALL_BLOCKS = MEMORY_BYTES / LINE_BYTES;
  localparam logic [DATA_W-1:0] RD_MASK = (WORD_BYTES >= 4) ? '1 :
                                          DATA_W'((64'd1 << (8 * WORD_BYTES)) - 64'd1);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_FILL   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [MEM_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [TIME_W-1:0]   time_r, time_nxt;
  logic [NUM_LINES-1:0] valid_r, valid_nxt;

  logic [COST_W-1:0]   mem_read_cost_r;
  logic [COST_W-1:0]   mem_write_cost_r;
  logic [COST_W-1:0]   cache_read_cost_r;
  logic [COST_W-1:0]   cache_write_cost_r;

  func_t               func_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   wdata_r;

  logic                out_valid_r;
  logic [DATA_W-1:0]   rsp_rdata_r;
  logic                rsp_hit_r;
  logic                rsp_err_r;
  logic [TIME_W-1:0]   rsp_time_r;

  logic                in_fire;
  logic                out_free;
  logic                finish;
  logic [DATA_W-1:0]   res_rdata;
  logic                res_hit;

  logic [IDX_W-1:0]    in_idx;
  logic [IDX_W-1:0]    req_idx;
  logic [TAG_W-1:0]    req_tag;
  logic [OFF_W-1:0]    req_off;
  logic [MEM_AW-1:0]   req_blk;
  logic [MEM_AW-1:0]   victim_blk;
  logic                req_err;
  logic                req_hit;

  logic                line_we;
  logic [ENT_W-1:0]    line_wdata;
  logic                line_re;
  logic [ENT_W-1:0]    line_rdata;
  logic                ent_dirty;
  logic [TAG_W-1:0]    ent_tag;
  logic [LINE_W-1:0]   ent_data;

  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [LINE_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [LINE_W-1:0]   mem_rdata;

  // Place one word into a line; bytes past the fourth are zero
  function automatic logic [LINE_W-1:0] merge_word(
    input logic [LINE_W-1:0] line,
    input logic [OFF_W-1:0]  off,
    input logic [DATA_W-1:0] wd
  );
    logic [LINE_W-1:0] res;
    int                rel;
    res = line;
    for (int b = 0; b < LINE_BYTES; b++) begin
      rel = b - int'(off);
      if (rel >= 0 && rel < int'(WORD_BYTES)) begin
        if (rel < 4) begin
          res[8*b +: 8] = wd[8*rel +: 8];
        end else begin
          res[8*b +: 8] = 8'd0;
        end
      end
    end
    return res;
  endfunction

  // Pick the word at a byte offset out of a line
  function automatic logic [DATA_W-1:0] extract_word(
    input logic [LINE_W-1:0] line,
    input logic [OFF_W-1:0]  off
  );
    logic [LINE_W-1:0] shifted;
    shifted = line >> {off, 3'b000};
    return shifted[DATA_W-1:0] & RD_MASK;
  endfunction

  // Handshakes
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign cfg_wr.ready = 1'b1;

  // Address split
  assign in_idx     = IDX_W'(32'(in_req.address >> OFF_W) & (NUM_LINES - 1));
  assign req_idx    = IDX_W'(32'(addr_r >> OFF_W) & (NUM_LINES - 1));
  assign req_tag    = TAG_W'(32'(addr_r) >> CACHE_SH);
  assign req_off    = addr_r[OFF_W-1:0];
  assign req_blk    = MEM_AW'(addr_r >> OFF_W);
  assign victim_blk = MEM_AW'((32'(ent_tag) << (CACHE_SH - OFF_W)) | 32'(req_idx));

  // Unaligned word, word crossing its line, or block past the end of memory
  assign req_err = ((32'(addr_r) & (WORD_BYTES - 1)) != 32'd0) ||
                   (32'(req_off) + WORD_BYTES > LINE_BYTES) ||
                   (32'(addr_r >> OFF_W) >= ALL_BLOCKS);

  // Line entry fields
  assign {ent_dirty, ent_tag, ent_data} = line_rdata;
  assign req_hit = valid_r[req_idx] && (ent_tag == req_tag);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    time_nxt    = time_r;
    valid_nxt   = valid_r;
    line_re     = 1'b0;
    line_we     = 1'b0;
    line_wdata  = {1'b0, req_tag, mem_rdata};
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = victim_blk;
    mem_wdata   = ent_data;
    finish      = 1'b0;
    res_rdata   = '0;
    res_hit     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == MEM_AW'(MEM_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          line_re   = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (func_r == FN_CLEAR_TIME || func_r == FN_INVALIDATE || req_err) begin
          // Control requests and bad addresses finish here; the address of a
          // control request is ignored
          if (out_free) begin
            finish    = 1'b1;
            state_nxt = ST_IDLE;
            if (func_r == FN_CLEAR_TIME) begin
              time_nxt = '0;
            end
            if (func_r == FN_INVALIDATE) begin
              valid_nxt = '0;
            end
          end
        end else if (req_hit) begin
          // Hit: serve the word from the line
          if (out_free) begin
            finish    = 1'b1;
            res_hit   = 1'b1;
            state_nxt = ST_IDLE;
            if (func_r == FN_READ) begin
              res_rdata = extract_word(ent_data, req_off);
              time_nxt  = time_r + TIME_W'(cache_read_cost_r);
            end else begin
              line_we    = 1'b1;
              line_wdata = {1'b1, req_tag, merge_word(ent_data, req_off, wdata_r)};
              time_nxt   = time_r + TIME_W'(cache_write_cost_r);
            end
          end
        end else begin
          // Miss: fetch the block, write back a dirty victim alongside
          mem_re    = 1'b1;
          state_nxt = ST_FILL;
          if (valid_r[req_idx] && ent_dirty) begin
            mem_we   = 1'b1;
            time_nxt = time_r + TIME_W'(mem_write_cost_r);
          end
        end
      end
      ST_FILL: begin
        // Install the fetched block and serve the word
        if (out_free) begin
          finish             = 1'b1;
          state_nxt          = ST_IDLE;
          line_we            = 1'b1;
          valid_nxt[req_idx] = 1'b1;
          if (func_r == FN_READ) begin
            line_wdata = {1'b0, req_tag, mem_rdata};
            res_rdata  = extract_word(mem_rdata, req_off);
            time_nxt   = time_r + TIME_W'(mem_read_cost_r) + TIME_W'(cache_read_cost_r);
          end else begin
            line_wdata = {1'b1, req_tag, merge_word(mem_rdata, req_off, wdata_r)};
            time_nxt   = time_r + TIME_W'(mem_read_cost_r) + TIME_W'(cache_write_cost_r);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      time_r    <= '0;
      valid_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      time_r    <= time_nxt;
      valid_r   <= valid_nxt;
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= func_t'(in_req.func);
      addr_r  <= in_req.address;
      wdata_r <= in_req.write_data;
    end
  end

  // Cost registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_read_cost_r    <= MEM_READ_COST_RST;
      mem_write_cost_r   <= MEM_WRITE_COST_RST;
      cache_read_cost_r  <= CACHE_READ_COST_RST;
      cache_write_cost_r <= CACHE_WRITE_COST_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        REG_MEM_READ_COST:    mem_read_cost_r    <= cfg_wr.data;
        REG_MEM_WRITE_COST:   mem_write_cost_r   <= cfg_wr.data;
        REG_CACHE_READ_COST:  cache_read_cost_r  <= cfg_wr.data;
        REG_CACHE_WRITE_COST: cache_write_cost_r <= cfg_wr.data;
        default: begin
        end
      endcase
    end
  end

  // Result register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_rdata_r <= res_rdata;
      rsp_hit_r   <= res_hit;
      rsp_err_r   <= req_err && (func_r == FN_READ || func_r == FN_WRITE);
      rsp_time_r  <= time_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.read_data    = rsp_rdata_r;
  assign out_rsp.hit          = rsp_hit_r;
  assign out_rsp.error        = rsp_err_r;
  assign out_rsp.elapsed_time = rsp_time_r;

  // Line store: dirty, tag and data per line
  dmwbc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (req_idx),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (in_idx),
    .rdata (line_rdata)
  );

  // Backing memory, one block per entry
  dmwbc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MEM_BLOCKS)
  ) u_mem_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (req_blk),
    .rdata (mem_rdata)
  );

endmodule

@@ verif/direct_mapped_writeback_cache_unit_tb.sv @@
// Self-checking testbench for the direct-mapped write-back cache unit: drives
// directed and random requests, predicts every result and compares it.
// Depends on dmwbc_pkg, the three channel interfaces and the cache unit RTL.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_unit_tb;
  import dmwbc_pkg::*;

  localparam int unsigned NUM_LINES  = CACHE_BYTES_DEF / LINE_BYTES_DEF;
  localparam int unsigned NUM_BLOCKS = MEMORY_BYTES_DEF / LINE_BYTES_DEF;
  localparam int unsigned OFF_W      = $clog2(LINE_BYTES_DEF);
  localparam int unsigned IDX_W      = $clog2(NUM_LINES);
  localparam int unsigned TAG_W      = ADDR_W - OFF_W - IDX_W;
  localparam int unsigned LINE_W     = LINE_BYTES_DEF * 8;

  localparam int IDLE_PCT        = 8;
  localparam int PHASE_ITEMS     = 308;
  localparam int BURST_ITEMS     = 40;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int MAX_REPORTS     = 50;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              error;
    logic [TIME_W-1:0] elapsed_time;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dmwbc_req_if req_if ();
  dmwbc_rsp_if rsp_if ();
  dmwbc_cfg_if cfg_if ();

  direct_mapped_writeback_cache_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if),
    .cfg_wr  (cfg_if)
  );

  always #2 clk = ~clk;

  // Predicted cache contents, backing memory, time counter and costs
  logic              line_ok    [NUM_LINES];
  logic              line_mod   [NUM_LINES];
  logic [TAG_W-1:0]  line_owner [NUM_LINES];
  logic [LINE_W-1:0] line_words [NUM_LINES];
  logic [LINE_W-1:0] mem_blocks [NUM_BLOCKS];
  logic [TIME_W-1:0] time_acc;
  logic [COST_W-1:0] cost_mem_rd;
  logic [COST_W-1:0] cost_mem_wr;
  logic [COST_W-1:0] cost_word_rd;
  logic [COST_W-1:0] cost_word_wr;

  cache_result_t expected_rsp_q [$];
  int            fail_count   = 0;
  int            stall_cycles = 0;

  // Shared between the request driver and the result receiver
  logic no_idle   = 1'b0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  // Apply one request to the predicted state and work out its result
  task automatic model_request(input func_t fn, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata,
                               output cache_result_t res);
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    int unsigned      offs;
    int unsigned      base;
    int               i;
    res  = '0;
    idx  = addr[OFF_W +: IDX_W];
    tag  = addr[ADDR_W-1 -: TAG_W];
    offs = addr % LINE_BYTES_DEF;
    base = addr - offs;
    case (fn)
      FN_CLEAR_TIME: begin
        time_acc = '0;
      end
      FN_INVALIDATE: begin
        // drop every line, dirty data included
        for (i = 0; i < NUM_LINES; i++) begin
          line_ok[i]    = 1'b0;
          line_mod[i]   = 1'b0;
          line_owner[i] = '0;
        end
      end
      default: begin
        if ((addr % WORD_BYTES_DEF) != 0 || offs + WORD_BYTES_DEF > LINE_BYTES_DEF ||
            base + LINE_BYTES_DEF > MEMORY_BYTES_DEF) begin
          res.error = 1'b1;
        end else begin
          if (line_ok[idx] && line_owner[idx] == tag) begin
            res.hit = 1'b1;
          end else begin
            // write back a dirty victim, then fill from memory
            if (line_ok[idx] && line_mod[idx]) begin
              mem_blocks[{line_owner[idx], idx}] = line_words[idx];
              time_acc = time_acc + cost_mem_wr;
            end
            line_words[idx] = mem_blocks[base / LINE_BYTES_DEF];
            time_acc        = time_acc + cost_mem_rd;
            line_ok[idx]    = 1'b1;
            line_mod[idx]   = 1'b0;
            line_owner[idx] = tag;
          end
          if (fn == FN_READ) begin
            res.read_data = line_words[idx][offs*8 +: DATA_W];
            time_acc      = time_acc + cost_word_rd;
          end else begin
            line_words[idx][offs*8 +: DATA_W] = wdata;
            line_mod[idx] = 1'b1;
            time_acc      = time_acc + cost_word_wr;
          end
        end
      end
    endcase
    res.elapsed_time = time_acc;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, want, got);
  endtask

  // Observe handshakes before each rising edge: check results, track
  // register writes, predict requests, and watch for a hang
  always @(negedge clk) begin : monitor
    cache_result_t want;
    cache_result_t res;
    logic          moved;
    moved = 1'b0;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("result with no request outstanding: elapsed_time 0x%08h",
                   rsp_if.elapsed_time);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_if.read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, rsp_if.read_data);
          if (rsp_if.hit !== want.hit)
            report_mismatch("hit", 32'(want.hit), 32'(rsp_if.hit));
          if (rsp_if.error !== want.error)
            report_mismatch("error", 32'(want.error), 32'(rsp_if.error));
          if (rsp_if.elapsed_time !== want.elapsed_time)
            report_mismatch("elapsed_time", want.elapsed_time, rsp_if.elapsed_time);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        case (cfg_reg_t'(cfg_if.index))
          REG_MEM_READ_COST:    cost_mem_rd  = cfg_if.data;
          REG_MEM_WRITE_COST:   cost_mem_wr  = cfg_if.data;
          REG_CACHE_READ_COST:  cost_word_rd = cfg_if.data;
          REG_CACHE_WRITE_COST: cost_word_wr = cfg_if.data;
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        model_request(func_t'(req_if.func), req_if.address, req_if.write_data, res);
        expected_rsp_q.push_back(res);
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen    <= hold_reqs;
      hold_left    <= RSP_HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one request, with an occasional gap first; return on the edge that takes it
  task automatic send_request(input func_t fn, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= fn;
    req_if.address    <= addr;
    req_if.write_data <= wdata;
    @(negedge clk);
    while (!req_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Stop offering and hold until every outstanding result is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cost(input cfg_reg_t r, input logic [COST_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data  <= v;
    @(negedge clk);
    while (!cfg_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_costs(input logic [COST_W-1:0] mem_rd, input logic [COST_W-1:0] mem_wr,
                           input logic [COST_W-1:0] word_rd,
                           input logic [COST_W-1:0] word_wr);
    write_cost(REG_MEM_READ_COST, mem_rd);
    write_cost(REG_MEM_WRITE_COST, mem_wr);
    write_cost(REG_CACHE_READ_COST, word_rd);
    write_cost(REG_CACHE_WRITE_COST, word_wr);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly accesses to a few hot sets so hits and dirty evictions are frequent
  task automatic run_random_traffic(input int count);
    int               k;
    int               sel;
    func_t            fn;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  tag;
    logic [IDX_W-1:0]  idx;
    int unsigned       word;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 47)      fn = FN_READ;
      else if (sel < 94) fn = FN_WRITE;
      else if (sel < 98) fn = FN_CLEAR_TIME;
      else               fn = FN_INVALIDATE;
      sel  = $urandom_range(99);
      addr = ADDR_W'($urandom);
      if (sel < 6) begin
        if (addr % WORD_BYTES_DEF == 0) addr = ADDR_W'(addr + 1);
      end else if (sel < 30) begin
        addr = ADDR_W'(addr - (addr % WORD_BYTES_DEF));
      end else begin
        tag = TAG_W'($urandom_range(0, 3));
        if (tag == 3) tag = '1;
        case ($urandom_range(0, 3))
          0:       idx = '0;
          1:       idx = IDX_W'(1);
          2:       idx = IDX_W'(NUM_LINES / 2);
          default: idx = '1;
        endcase
        word = $urandom_range(0, LINE_BYTES_DEF / WORD_BYTES_DEF - 1);
        addr = {tag, idx, OFF_W'(word * WORD_BYTES_DEF)};
      end
      send_request(fn, addr, $urandom);
    end
  endtask

  // Reset costs: misses, hits, dirty eviction, bad addresses, clear, invalidate
  task automatic test_directed_cases();
    send_request(FN_READ,  16'h0000, 32'h0000_0000);
    send_request(FN_WRITE, 16'h0000, 32'hFFFF_FFFF);
    send_request(FN_WRITE, 16'h0004, 32'h0000_0000);
    send_request(FN_WRITE, 16'h000C, 32'hA5A5_5A5A);
    send_request(FN_READ,  16'h000C, 32'h0000_0000);
    send_request(FN_READ,  16'h1000, 32'h1234_5678);
    send_request(FN_READ,  16'h0000, 32'h0000_0000);
    send_request(FN_READ,  16'hFFFC, 32'h0000_0000);
    send_request(FN_WRITE, 16'hFFFC, 32'h8000_0001);
    send_request(FN_READ,  16'h0001, 32'h0000_0000);
    send_request(FN_WRITE, 16'h0002, 32'hDEAD_BEEF);
    send_request(FN_READ,  16'hFFFF, 32'h0000_0000);
    send_request(FN_WRITE, 16'h0003, 32'hFFFF_FFFF);
    send_request(FN_CLEAR_TIME, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FN_INVALIDATE, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(FN_READ,  16'hFFFC, 32'h0000_0000);
    send_request(FN_READ,  16'h0000, 32'h0000_0000);
    send_request(FN_WRITE, 16'h5550, 32'h1234_5678);
    send_request(FN_WRITE, 16'hA550, 32'h8765_4321);
    send_request(FN_READ,  16'h5550, 32'h0000_0000);
    send_request(FN_CLEAR_TIME, 16'h0000, 32'h0000_0000);
    drain_results();
  endtask

  task automatic test_zero_costs();
    set_costs('0, '0, '0, '0);
    run_random_traffic(PHASE_ITEMS);
    drain_results();
  endtask

  // Largest costs on every register; run back to back with no stalls
  task automatic test_max_costs_back_to_back();
    no_idle <= 1'b1;
    set_costs('1, '1, '1, '1);
    run_random_traffic(PHASE_ITEMS);
    drain_results();
    no_idle <= 1'b0;
  endtask

  task automatic test_random_costs();
    set_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom), COST_W'($urandom));
    run_random_traffic(PHASE_ITEMS);
    drain_results();
  endtask

  task automatic test_mixed_extreme_costs();
    set_costs('1, '0, '0, '1);
    run_random_traffic(PHASE_ITEMS);
    drain_results();
  endtask

  // Hold the result side while requests keep coming so the unit backs up
  task automatic test_result_backpressure();
    hold_reqs <= hold_reqs + 1;
    no_idle   <= 1'b1;
    run_random_traffic(BURST_ITEMS);
    drain_results();
    no_idle   <= 1'b0;
  endtask

  initial begin
    int i;
    req_if.valid      = 1'b0;
    req_if.func       = FN_READ;
    req_if.address    = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_MEM_READ_COST;
    cfg_if.data       = '0;
    for (i = 0; i < NUM_LINES; i++) begin
      line_ok[i]    = 1'b0;
      line_mod[i]   = 1'b0;
      line_owner[i] = '0;
      line_words[i] = '0;
    end
    for (i = 0; i < NUM_BLOCKS; i++) mem_blocks[i] = '0;
    time_acc     = '0;
    cost_mem_rd  = MEM_READ_COST_RST;
    cost_mem_wr  = MEM_WRITE_COST_RST;
    cost_word_rd = CACHE_READ_COST_RST;
    cost_word_wr = CACHE_WRITE_COST_RST;

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_zero_costs();
    test_max_costs_back_to_back();
    test_random_costs();
    test_mixed_extreme_costs();
    test_result_backpressure();
    drain_results();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dmwbc_pkg.sv
hw/rtl/dmwbc_req_if.sv
hw/rtl/dmwbc_rsp_if.sv
hw/rtl/dmwbc_cfg_if.sv
hw/rtl/dmwbc_ram.sv
hw/rtl/direct_mapped_writeback_cache_unit.sv
verif/direct_mapped_writeback_cache_unit_tb.sv
